### src/gripper_current_stop_sequencer_assert.svh
// Assertion macros for the gripper current-stop sequencer.
`ifndef GRIPPER_CURRENT_STOP_SEQUENCER_ASSERT_SVH
`define GRIPPER_CURRENT_STOP_SEQUENCER_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define GCSS_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("gcss same-cycle check failed");

// next-cycle implication, sampled on clk, off during reset
`define GCSS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("gcss next-cycle check failed");

`endif

### src/gcss_pkg.sv
// Shared widths, constants, register indexes and pulse helper for the gripper sequencer.
package gcss_pkg;

	localparam int CMD_W     = 2;
	localparam int CURRENT_W = 12;
	localparam int SPEED_W   = 9;
	localparam int PULSE_W   = 11;
	localparam int MODE_W    = 3;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 12;

	localparam logic [CMD_W-1:0] CMD_NONE  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_CLOSE = 2'd1;
	localparam logic [CMD_W-1:0] CMD_OPEN  = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_A   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_B   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_REVERSE_A = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_REVERSE_B = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_SPEED_A   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_SPEED_B   = 3'd5;

	localparam logic [PULSE_W-1:0] PULSE_MID = 11'd1500;
	localparam logic [PULSE_W-1:0] PULSE_MIN = 11'd1000;
	localparam logic [PULSE_W-1:0] PULSE_MAX = 11'd2000;

	// pulse while winding: mid plus speed when direction adds, else minus, clamped
	function automatic logic [PULSE_W-1:0] winding_pulse(
		logic [SPEED_W-1:0] spd,
		logic               rev,
		logic               opening
	);
		logic [PULSE_W-1:0] p;
		if (rev ^ opening) begin
			p = PULSE_MID + PULSE_W'(spd);
		end else begin
			p = PULSE_MID - PULSE_W'(spd);
		end
		if (p < PULSE_MIN) begin
			p = PULSE_MIN;
		end
		if (p > PULSE_MAX) begin
			p = PULSE_MAX;
		end
		return p;
	endfunction

endpackage

### src/gcss_if.sv
// Channel interfaces of the gripper sequencer: configuration, command tick and status.
interface gcss_cfg_if;
	import gcss_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

interface gcss_cmd_if;
	import gcss_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [CMD_W-1:0]     command;
	logic                 manual_hold;
	logic [CURRENT_W-1:0] current_a_ma;
	logic [CURRENT_W-1:0] current_b_ma;
	modport source (output valid, command, manual_hold, current_a_ma, current_b_ma,
		input ready);
	modport sink (input valid, command, manual_hold, current_a_ma, current_b_ma,
		output ready);
endinterface

interface gcss_status_if;
	import gcss_pkg::*;
	logic               valid;
	logic               ready;
	logic [PULSE_W-1:0] pulse_a_us;
	logic [PULSE_W-1:0] pulse_b_us;
	logic               power_on;
	logic               grasp_complete;
	logic               release_complete;
	logic [MODE_W-1:0]  coordinator_mode;
	modport source (output valid, pulse_a_us, pulse_b_us, power_on, grasp_complete,
		release_complete, coordinator_mode, input ready);
	modport sink (input valid, pulse_a_us, pulse_b_us, power_on, grasp_complete,
		release_complete, coordinator_mode, output ready);
endinterface

### src/gripper_current_stop_sequencer.sv
// Gripper current-stop sequencer: two winch machines and a grasp/release coordinator.
// Status: each tick's status is registered and appears in the cycle after the command transaction is accepted.
// Throughput: one tick per cycle; the state registers double as the status register,
// so a new tick is taken whenever the status output is empty or being taken.
// Reset: arst_n clears all state, configuration to zero, pulses to 1500 us, status empty.
// Configuration writes are always ready and take effect on the next tick.
module gripper_current_stop_sequencer (
	input  logic                 clk,
	input  logic                 arst_n,
	gcss_cfg_if.sink             cfg,
	gcss_cmd_if.sink             cmd,
	gcss_status_if.source        status
);
	import gcss_pkg::*;

	typedef enum logic [MODE_W-1:0] {
		MODE_REST    = 3'd0,
		MODE_CLOSING = 3'd1,
		MODE_CLOSED  = 3'd2,
		MODE_OPENING = 3'd3,
		MODE_OPENED  = 3'd4
	} mode_t;

	logic [CURRENT_W-1:0] limit_q [2];
	logic [1:0]           reverse_q;
	logic [SPEED_W-1:0]   speed_q [2];

	mode_t              coord_mode_q, coord_mode_n;
	logic               pend_grasp_q, pend_grasp_n;
	logic               pend_release_q, pend_release_n;
	logic               grasp_flag_q, grasp_flag_n;
	logic               release_flag_q, release_flag_n;
	mode_t              winch_mode_q [2];
	mode_t              winch_mode_n [2];
	logic [1:0]         close_req_q, close_req_n;
	logic [1:0]         open_req_q, open_req_n;
	logic [1:0]         close_fin_q, close_fin_n;
	logic [1:0]         open_fin_q, open_fin_n;
	logic [PULSE_W-1:0] pulse_q [2];
	logic [PULSE_W-1:0] pulse_n [2];
	logic [1:0]         users_q, users_n;
	logic               out_valid_q;

	logic                 accept;
	logic [CURRENT_W-1:0] current [2];
	logic [1:0]           acquire;
	logic [1:0]           release_pwr;
	logic [1:0]           active_cnt;
	logic                 closed_tick;

	function automatic logic [1:0] users_step(logic [1:0] u, logic acq, logic rel);
		logic [1:0] r;
		r = u;
		if (acq && u != 2'd3) begin
			r = u + 2'd1;
		end else if (rel && u != 2'd0) begin
			r = u - 2'd1;
		end
		return r;
	endfunction

	assign cfg.ready  = 1'b1;
	assign cmd.ready  = !out_valid_q || status.ready;
	assign accept     = cmd.valid && cmd.ready;
	assign current[0] = cmd.current_a_ma;
	assign current[1] = cmd.current_b_ma;

	always_comb begin
		pend_grasp_n   = pend_grasp_q || (cmd.command == CMD_CLOSE);
		pend_release_n = pend_release_q || (cmd.command == CMD_OPEN);
		coord_mode_n   = coord_mode_q;
		grasp_flag_n   = grasp_flag_q;
		release_flag_n = release_flag_q;
		close_req_n    = close_req_q;
		open_req_n     = open_req_q;
		close_fin_n    = close_fin_q;
		open_fin_n     = open_fin_q;
		acquire        = 2'b00;
		release_pwr    = 2'b00;
		for (int w = 0; w < 2; w++) begin
			winch_mode_n[w] = winch_mode_q[w];
			pulse_n[w]      = pulse_q[w];
		end
		users_n = users_q;

		if (!cmd.manual_hold) begin
			for (int w = 0; w < 2; w++) begin
				case (winch_mode_q[w])
					MODE_REST: begin
						if (close_req_q[w]) begin
							pulse_n[w]      = PULSE_MID;
							acquire[w]      = 1'b1;
							close_req_n[w]  = 1'b0;
							close_fin_n[w]  = 1'b0;
							winch_mode_n[w] = MODE_CLOSING;
						end else if (open_req_q[w]) begin
							pulse_n[w]      = PULSE_MID;
							acquire[w]      = 1'b1;
							open_req_n[w]   = 1'b0;
							open_fin_n[w]   = 1'b0;
							winch_mode_n[w] = MODE_OPENING;
						end
					end
					MODE_CLOSING: begin
						pulse_n[w] = winding_pulse(speed_q[w], reverse_q[w], 1'b0);
						if (current[w] > limit_q[w]) begin
							winch_mode_n[w] = MODE_CLOSED;
						end
					end
					MODE_CLOSED: begin
						release_pwr[w]  = 1'b1;
						close_fin_n[w]  = 1'b1;
						winch_mode_n[w] = MODE_REST;
					end
					MODE_OPENING: begin
						pulse_n[w] = winding_pulse(speed_q[w], reverse_q[w], 1'b1);
						if (current[w] > limit_q[w]) begin
							winch_mode_n[w] = MODE_OPENED;
						end
					end
					MODE_OPENED: begin
						release_pwr[w]  = 1'b1;
						open_fin_n[w]   = 1'b1;
						winch_mode_n[w] = MODE_REST;
					end
					default: begin
						winch_mode_n[w] = MODE_REST;
					end
				endcase
			end
			users_n = users_step(users_step(users_q, acquire[0], release_pwr[0]),
				acquire[1], release_pwr[1]);

			case (coord_mode_q)
				MODE_REST: begin
					if (pend_grasp_n) begin
						close_req_n    = 2'b11;
						open_req_n     = 2'b00;
						pend_grasp_n   = 1'b0;
						grasp_flag_n   = 1'b0;
						coord_mode_n   = MODE_CLOSING;
					end else if (pend_release_n) begin
						close_req_n    = 2'b00;
						open_req_n     = 2'b11;
						pend_release_n = 1'b0;
						release_flag_n = 1'b0;
						coord_mode_n   = MODE_OPENING;
					end
				end
				MODE_CLOSING: begin
					if (close_fin_n[0] && close_fin_n[1]) begin
						coord_mode_n = MODE_CLOSED;
					end
				end
				MODE_CLOSED: begin
					grasp_flag_n = 1'b1;
					coord_mode_n = MODE_REST;
				end
				MODE_OPENING: begin
					if (open_fin_n[0] && open_fin_n[1]) begin
						coord_mode_n = MODE_OPENED;
					end
				end
				MODE_OPENED: begin
					release_flag_n = 1'b1;
					coord_mode_n   = MODE_REST;
				end
				default: begin
					coord_mode_n = MODE_REST;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q[0] <= '0;
			limit_q[1] <= '0;
			reverse_q  <= '0;
			speed_q[0] <= '0;
			speed_q[1] <= '0;
		end else if (cfg.valid) begin
			case (cfg.index)
				CFG_LIMIT_A:   limit_q[0]   <= cfg.data;
				CFG_LIMIT_B:   limit_q[1]   <= cfg.data;
				CFG_REVERSE_A: reverse_q[0] <= cfg.data[0];
				CFG_REVERSE_B: reverse_q[1] <= cfg.data[0];
				CFG_SPEED_A:   speed_q[0]   <= cfg.data[SPEED_W-1:0];
				CFG_SPEED_B:   speed_q[1]   <= cfg.data[SPEED_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coord_mode_q    <= MODE_REST;
			pend_grasp_q    <= 1'b0;
			pend_release_q  <= 1'b0;
			grasp_flag_q    <= 1'b0;
			release_flag_q  <= 1'b0;
			winch_mode_q[0] <= MODE_REST;
			winch_mode_q[1] <= MODE_REST;
			close_req_q     <= '0;
			open_req_q      <= '0;
			close_fin_q     <= '0;
			open_fin_q      <= '0;
			pulse_q[0]      <= PULSE_MID;
			pulse_q[1]      <= PULSE_MID;
			users_q         <= '0;
			out_valid_q     <= 1'b0;
		end else begin
			if (accept) begin
				coord_mode_q    <= coord_mode_n;
				pend_grasp_q    <= pend_grasp_n;
				pend_release_q  <= pend_release_n;
				grasp_flag_q    <= grasp_flag_n;
				release_flag_q  <= release_flag_n;
				winch_mode_q[0] <= winch_mode_n[0];
				winch_mode_q[1] <= winch_mode_n[1];
				close_req_q     <= close_req_n;
				open_req_q      <= open_req_n;
				close_fin_q     <= close_fin_n;
				open_fin_q      <= open_fin_n;
				pulse_q[0]      <= pulse_n[0];
				pulse_q[1]      <= pulse_n[1];
				users_q         <= users_n;
				out_valid_q     <= 1'b1;
			end else if (status.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign status.valid            = out_valid_q;
	assign status.pulse_a_us       = pulse_q[0];
	assign status.pulse_b_us       = pulse_q[1];
	assign status.power_on         = (users_q != 2'd0);
	assign status.grasp_complete   = grasp_flag_q;
	assign status.release_complete = release_flag_q;
	assign status.coordinator_mode = coord_mode_q;

	assign active_cnt = {1'b0, winch_mode_q[0] != MODE_REST}
		+ {1'b0, winch_mode_q[1] != MODE_REST};
	assign closed_tick = accept && !cmd.manual_hold && coord_mode_q == MODE_CLOSED;

`include "gripper_current_stop_sequencer_assert.svh"

	`GCSS_ASSERT_NOW(a_users_match_active, 1'b1, users_q == active_cnt)
	`GCSS_ASSERT_NEXT(a_stall_freezes_state, !cmd.ready, $stable(coord_mode_q) && $stable(users_q))
	`GCSS_ASSERT_NEXT(a_closed_sets_flag, closed_tick, grasp_flag_q && coord_mode_q == MODE_REST)

endmodule

### tb/sv/tb.sv
// Testbench for the gripper current-stop sequencer: scoreboard class, drivers and top module.

class gripper_scoreboard;
	typedef struct packed {
		logic [10:0] pulse_a;
		logic [10:0] pulse_b;
		logic        power;
		logic        grasp_ok;
		logic        release_ok;
		logic [2:0]  mode;
	} status_t;

	localparam bit [2:0] MODE_REST    = 3'd0;
	localparam bit [2:0] MODE_CLOSING = 3'd1;
	localparam bit [2:0] MODE_CLOSED  = 3'd2;
	localparam bit [2:0] MODE_OPENING = 3'd3;
	localparam bit [2:0] MODE_OPENED  = 3'd4;
	localparam int       ENABLE_MAX   = 3;

	bit [11:0] limit_ma[2];
	bit        reverse_dir[2];
	bit [8:0]  speed[2];

	bit [2:0]  coord_mode;
	bit        pend_grasp, pend_release, grasp_flag, release_flag;
	bit [2:0]  winch_mode[2];
	bit        close_req[2], open_req[2], close_fin[2], open_fin[2];
	bit [10:0] pulse[2];
	int        users;

	status_t   status_q[$];
	int        errors, checked, ticks, grasps, releases;

	function new();
		coord_mode = MODE_REST;
		for (int w = 0; w < 2; w++) begin
			limit_ma[w] = '0;
			reverse_dir[w] = 1'b0;
			speed[w] = '0;
			winch_mode[w] = MODE_REST;
			pulse[w] = gcss_pkg::PULSE_MID;
		end
	endfunction

	function void write_reg(bit [2:0] idx, bit [11:0] data);
		case (idx)
			gcss_pkg::CFG_LIMIT_A:   limit_ma[0] = data;
			gcss_pkg::CFG_LIMIT_B:   limit_ma[1] = data;
			gcss_pkg::CFG_REVERSE_A: reverse_dir[0] = data[0];
			gcss_pkg::CFG_REVERSE_B: reverse_dir[1] = data[0];
			gcss_pkg::CFG_SPEED_A:   speed[0] = data[8:0];
			gcss_pkg::CFG_SPEED_B:   speed[1] = data[8:0];
			default: ;
		endcase
	endfunction

	// adds speed when direction flag matches closing
	function bit [10:0] drive_pulse(int w, bit closing);
		int p;
		if (reverse_dir[w] == closing) begin
			p = int'(gcss_pkg::PULSE_MID) + int'(speed[w]);
		end else begin
			p = int'(gcss_pkg::PULSE_MID) - int'(speed[w]);
		end
		if (p < int'(gcss_pkg::PULSE_MIN)) begin
			p = int'(gcss_pkg::PULSE_MIN);
		end
		if (p > int'(gcss_pkg::PULSE_MAX)) begin
			p = int'(gcss_pkg::PULSE_MAX);
		end
		return p[10:0];
	endfunction

	function void step_winch(int w, bit [11:0] cur);
		case (winch_mode[w])
			MODE_REST: begin
				if (close_req[w]) begin
					pulse[w] = gcss_pkg::PULSE_MID;
					if (users < ENABLE_MAX) users++;
					close_req[w] = 1'b0;
					close_fin[w] = 1'b0;
					winch_mode[w] = MODE_CLOSING;
				end else if (open_req[w]) begin
					pulse[w] = gcss_pkg::PULSE_MID;
					if (users < ENABLE_MAX) users++;
					open_req[w] = 1'b0;
					open_fin[w] = 1'b0;
					winch_mode[w] = MODE_OPENING;
				end
			end
			MODE_CLOSING: begin
				pulse[w] = drive_pulse(w, 1'b1);
				if (cur > limit_ma[w]) winch_mode[w] = MODE_CLOSED;
			end
			MODE_CLOSED: begin
				if (users > 0) users--;
				close_fin[w] = 1'b1;
				winch_mode[w] = MODE_REST;
			end
			MODE_OPENING: begin
				pulse[w] = drive_pulse(w, 1'b0);
				if (cur > limit_ma[w]) winch_mode[w] = MODE_OPENED;
			end
			MODE_OPENED: begin
				if (users > 0) users--;
				open_fin[w] = 1'b1;
				winch_mode[w] = MODE_REST;
			end
			default: winch_mode[w] = MODE_REST;
		endcase
	endfunction

	function void step_coord();
		case (coord_mode)
			MODE_REST: begin
				if (pend_grasp || pend_release) begin
					for (int w = 0; w < 2; w++) begin
						close_req[w] = pend_grasp;
						open_req[w] = !pend_grasp;
					end
					if (pend_grasp) begin
						pend_grasp = 1'b0;
						grasp_flag = 1'b0;
						coord_mode = MODE_CLOSING;
					end else begin
						pend_release = 1'b0;
						release_flag = 1'b0;
						coord_mode = MODE_OPENING;
					end
				end
			end
			MODE_CLOSING: if (close_fin[0] && close_fin[1]) coord_mode = MODE_CLOSED;
			MODE_CLOSED: begin
				grasp_flag = 1'b1;
				grasps++;
				coord_mode = MODE_REST;
			end
			MODE_OPENING: if (open_fin[0] && open_fin[1]) coord_mode = MODE_OPENED;
			MODE_OPENED: begin
				release_flag = 1'b1;
				releases++;
				coord_mode = MODE_REST;
			end
			default: coord_mode = MODE_REST;
		endcase
	endfunction

	function void note_tick(bit [1:0] c, bit h, bit [11:0] a, bit [11:0] b);
		status_t s;
		if (c == gcss_pkg::CMD_CLOSE) begin
			pend_grasp = 1'b1;
		end else if (c == gcss_pkg::CMD_OPEN) begin
			pend_release = 1'b1;
		end
		if (!h) begin
			step_winch(0, a);
			step_winch(1, b);
			step_coord();
		end
		s.pulse_a = pulse[0];
		s.pulse_b = pulse[1];
		s.power = (users != 0);
		s.grasp_ok = grasp_flag;
		s.release_ok = release_flag;
		s.mode = coord_mode;
		status_q.push_back(s);
		ticks++;
	endfunction

	function void compare(string field, int unsigned want, int unsigned got);
		if (want != got) begin
			$display("%0t: %s expected %0d actual %0d", $time, field, want, got);
			errors++;
		end
	endfunction

	function void check_status(status_t got);
		status_t want;
		if (status_q.size() == 0) begin
			$display("%0t: status transaction expected none actual %p", $time, got);
			errors++;
			return;
		end
		want = status_q.pop_front();
		checked++;
		compare("pulse_a_us", want.pulse_a, got.pulse_a);
		compare("pulse_b_us", want.pulse_b, got.pulse_b);
		compare("power_on", want.power, got.power);
		compare("grasp_complete", want.grasp_ok, got.grasp_ok);
		compare("release_complete", want.release_ok, got.release_ok);
		compare("coordinator_mode", want.mode, got.mode);
	endfunction

	function int pending();
		return status_q.size();
	endfunction
endclass

module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import gcss_pkg::*;

	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
	localparam int CYCLE_LIMIT = 500000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int   idle_pct = 0;
	int   stall_pct = 0;
	int   cycles = 0;
	gripper_scoreboard sb;

	gcss_cfg_if    cfg();
	gcss_cmd_if    cmd();
	gcss_status_if status();

	gripper_current_stop_sequencer dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.cmd    (cmd),
		.status (status)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		status.ready <= ($urandom_range(99) >= stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg.valid && cfg.ready) sb.write_reg(cfg.index, cfg.data);
			if (cmd.valid && cmd.ready) begin
				sb.note_tick(cmd.command, cmd.manual_hold, cmd.current_a_ma, cmd.current_b_ma);
			end
			if (status.valid && status.ready) begin
				sb.check_status({status.pulse_a_us, status.pulse_b_us, status.power_on,
					status.grasp_complete, status.release_complete, status.coordinator_mode});
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("FAIL");
			$finish;
		end
	end

	task automatic send_tick(logic [CMD_W-1:0] c, logic h, logic [CURRENT_W-1:0] a,
		logic [CURRENT_W-1:0] b);
		while ($urandom_range(99) < idle_pct) begin
			cmd.valid <= 1'b0;
			@(posedge clk);
		end
		cmd.valid <= 1'b1;
		cmd.command <= c;
		cmd.manual_hold <= h;
		cmd.current_a_ma <= a;
		cmd.current_b_ma <= b;
		@(posedge clk);
		while (!cmd.ready) @(posedge clk);
	endtask

	task automatic wait_drain();
		cmd.valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic apply_config(logic [11:0] lim_a, logic [11:0] lim_b, logic [11:0] rev_a,
		logic [11:0] rev_b, logic [11:0] spd_a, logic [11:0] spd_b);
		logic [CFG_IDX_W-1:0]  idx[6];
		logic [CFG_DATA_W-1:0] val[6];
		idx = '{CFG_LIMIT_A, CFG_LIMIT_B, CFG_REVERSE_A, CFG_REVERSE_B, CFG_SPEED_A, CFG_SPEED_B};
		val = '{lim_a, lim_b, rev_a, rev_b, spd_a, spd_b};
		for (int i = 0; i < 6; i++) begin
			cfg.valid <= 1'b1;
			cfg.index <= idx[i];
			cfg.data <= val[i];
			@(posedge clk);
			while (!cfg.ready) @(posedge clk);
		end
		cfg.valid <= 1'b0;
	endtask

	// mostly below the limit so winding lasts a few ticks, with the boundary and full range mixed in
	function automatic logic [CURRENT_W-1:0] pick_current(logic [CURRENT_W-1:0] lim);
		int r;
		r = $urandom_range(9);
		if (r < 2) return CURRENT_W'($urandom_range(4095));
		if (r < 4) return lim;
		if (r == 4) return (lim == 12'hFFF) ? lim : lim + 12'd1;
		return CURRENT_W'($urandom_range(int'(lim), 0));
	endfunction

	task automatic random_tick();
		logic [CMD_W-1:0] c;
		int r;
		r = $urandom_range(99);
		if (r < 70) c = CMD_NONE;
		else if (r < 82) c = CMD_CLOSE;
		else if (r < 94) c = CMD_OPEN;
		else c = CMD_UNUSED;
		send_tick(c, ($urandom_range(9) == 0), pick_current(sb.limit_ma[0]),
			pick_current(sb.limit_ma[1]));
	endtask

	initial begin
		int n;
		cfg.valid = 1'b0;
		cfg.index = '0;
		cfg.data = '0;
		cmd.valid = 1'b0;
		cmd.command = CMD_NONE;
		cmd.manual_hold = 1'b0;
		cmd.current_a_ma = '0;
		cmd.current_b_ma = '0;
		sb = new();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset configuration: zero limits, any nonzero current stops
		send_tick(CMD_CLOSE, 1'b0, 12'd0, 12'd0);
		send_tick(CMD_NONE, 1'b0, 12'd0, 12'd0);
		send_tick(CMD_NONE, 1'b0, 12'd1, 12'd0);
		send_tick(CMD_NONE, 1'b0, 12'd0, 12'd4095);
		wait_drain();

		apply_config(12'd100, 12'd200, 12'd1, 12'd0, 12'd500, 12'd511);
		send_tick(CMD_NONE, 1'b0, 12'd0, 12'd0);
		send_tick(CMD_UNUSED, 1'b0, 12'd4095, 12'd4095);
		send_tick(CMD_CLOSE, 1'b1, 12'd4095, 12'd4095);
		send_tick(CMD_OPEN, 1'b1, 12'd0, 12'd0);
		send_tick(CMD_NONE, 1'b0, 12'd0, 12'd0);
		send_tick(CMD_NONE, 1'b0, 12'd0, 12'd0);
		send_tick(CMD_NONE, 1'b0, 12'd100, 12'd200);
		send_tick(CMD_NONE, 1'b1, 12'd4095, 12'd4095);
		send_tick(CMD_NONE, 1'b0, 12'd101, 12'd0);
		send_tick(CMD_CLOSE, 1'b0, 12'd0, 12'd201);
		send_tick(CMD_NONE, 1'b0, 12'd0, 12'd0);
		send_tick(CMD_NONE, 1'b0, 12'd0, 12'd0);
		send_tick(CMD_NONE, 1'b0, 12'd0, 12'd0);
		send_tick(CMD_NONE, 1'b0, 12'd0, 12'd0);
		send_tick(CMD_NONE, 1'b0, 12'd4095, 12'd4095);
		send_tick(CMD_NONE, 1'b0, 12'd0, 12'd0);
		send_tick(CMD_NONE, 1'b0, 12'd0, 12'd0);
		send_tick(CMD_NONE, 1'b0, 12'd0, 12'd0);
		send_tick(CMD_NONE, 1'b0, 12'd0, 12'd0);
		send_tick(CMD_NONE, 1'b0, 12'd4095, 12'd4095);
		send_tick(CMD_NONE, 1'b0, 12'd0, 12'd0);

		for (int ph = 0; ph < 8; ph++) begin
			wait_drain();
			case (ph)
				0: apply_config(12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0);
				1: apply_config(12'hFFF, 12'hFFF, 12'd1, 12'd1, 12'd511, 12'd511);
				default: begin
					apply_config(($urandom_range(3) == 0) ? 12'($urandom_range(4095))
							: 12'($urandom_range(600)),
						($urandom_range(3) == 0) ? 12'($urandom_range(4095))
							: 12'($urandom_range(600)),
						12'($urandom_range(4095)), 12'($urandom_range(4095)),
						12'($urandom_range(4095)), 12'($urandom_range(4095)));
				end
			endcase
			case (ph % 4)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 75; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 75; end
				default: begin idle_pct = 32; stall_pct = 32; end
			endcase
			n = (ph == 1) ? 100 : 250;
			repeat (n) random_tick();
		end

		wait_drain();
		$display("ran %0d ticks over 10 configurations, %0d status transactions checked",
			sb.ticks, sb.checked);
		$display("grasps completed %0d, releases completed %0d, mismatches %0d",
			sb.grasps, sb.releases, sb.errors);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end
endmodule

### filelist.f
+incdir+src
src/gcss_pkg.sv
src/gcss_if.sv
src/gripper_current_stop_sequencer.sv
tb/sv/tb.sv
